>>> rtl/ivr_pkg.sv
// shared constants and codes for the in-place vector rotate block
package ivr_pkg;

  // store geometry
  localparam int DEPTH  = 1024;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int LEN_W  = 11;
  localparam int ELEM_W = 32;
  localparam int DATA_W = 32;

  // input transaction fields inside s_axis_tdata
  localparam int IN_TDATA_W = 56;
  localparam int IDX_LSB    = 0;
  localparam int WV_LSB     = 10;
  localparam int DIST_LSB   = 42;

  // action codes
  localparam logic [1:0] ACT_WRITE  = 2'd0;
  localparam logic [1:0] ACT_READ   = 2'd1;
  localparam logic [1:0] ACT_ROTATE = 2'd2;

  // status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_IDX  = 2'd1;
  localparam logic [1:0] ST_BAD_DIST = 2'd2;

endpackage

>>> rtl/in_place_vector_rotate.sv
// top level: element store with write, read and in-place juggling rotate
//
// A write, an out-of-range request, the unused action and a trivial rotate finish in the
// cycle they are accepted; a read finishes in S_READ, after the registered memory read. A
// rotate over length L by distance d with g = gcd(d, L) runs through the accept cycle,
// the one-per-cycle subtract or swap steps of the gcd unit (the most for a distance of 1
// or L - 1) and a step in which the gcd is seen done, then for each of the g orbits of
// the permutation a load step, a move step per element moved through the single read and
// single write port of the store and a close step that writes the held element back. A
// finished result sits in an output register with one pending slot behind it, so a new
// transaction is taken while the previous result still waits, if the pending slot is
// empty. The store is not cleared at reset; read only elements that were written.
// vector_length resets to 1024 and is capped at 1024.
module in_place_vector_rotate (
  input  logic        clk,
  input  logic        rst,
  // configuration: vector_length
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [10:0] cfg_data,
  // input transactions
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [55:0] s_axis_tdata,   // element_index[9:0], write_value[41:10],
                                      // rotate_distance[52:42], zero fill
  input  logic [1:0]  s_axis_tuser,   // action[1:0]
  // result transactions
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // read_data[31:0]
  output logic [1:0]  m_axis_tuser    // status[1:0]
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_READ  = 3'd1;
  localparam logic [2:0] S_GCD   = 3'd2;
  localparam logic [2:0] S_HELD  = 3'd3;
  localparam logic [2:0] S_MOVE  = 3'd4;
  localparam logic [2:0] S_CLOSE = 3'd5;

  localparam int AW = ivr_pkg::ADDR_W;
  localparam int LW = ivr_pkg::LEN_W;
  localparam int DW = ivr_pkg::DATA_W;

  logic [2:0]    state;
  logic [LW-1:0] vector_length;
  logic [LW-1:0] len_eff;
  logic [LW-1:0] rot_len;
  logic [LW-1:0] rot_dist;
  logic [LW-1:0] cycles;
  logic [AW-1:0] start;
  logic [AW-1:0] cur;
  logic [AW-1:0] ptr;
  logic [DW-1:0] held;

  logic          accept;
  logic [1:0]    in_action;
  logic [AW-1:0] in_index;
  logic [DW-1:0] in_value;
  logic [LW-1:0] in_dist;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [DW-1:0] mem_wdata;
  logic [AW-1:0] mem_raddr;
  logic [DW-1:0] mem_rdata;

  logic          gcd_start;
  logic          gcd_done;
  logic [LW-1:0] gcd_result;

  logic [AW-1:0] step_src;
  logic [LW:0]   step_sum;
  logic [AW-1:0] step_nxt;
  logic [AW-1:0] start_inc;
  logic          last_cycle;

  logic          done_valid;
  logic [DW-1:0] done_data;
  logic [1:0]    done_status;

  logic          out_valid;
  logic [DW-1:0] out_data;
  logic [1:0]    out_status;
  logic          pending;
  logic [DW-1:0] pend_data;
  logic [1:0]    pend_status;
  logic          out_free;

  // field unpacking
  assign in_action = s_axis_tuser;
  assign in_index  = s_axis_tdata[ivr_pkg::IDX_LSB +: AW];
  assign in_value  = s_axis_tdata[ivr_pkg::WV_LSB +: DW];
  assign in_dist   = s_axis_tdata[ivr_pkg::DIST_LSB +: LW];

  // configuration register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      vector_length <= LW'(ivr_pkg::DEPTH);
    end else if (cfg_valid && cfg_ready) begin
      vector_length <= cfg_data;
    end
  end

  assign len_eff = (vector_length > LW'(ivr_pkg::DEPTH)) ? LW'(ivr_pkg::DEPTH)
                                                         : vector_length;

  // handshake
  assign s_axis_tready = (state == S_IDLE) && !pending;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // next position in the permutation cycle, with one wrap
  assign step_src = (state == S_HELD) ? start : ptr;
  assign step_sum = {2'b00, step_src} + {1'b0, rot_dist};
  assign step_nxt = (step_sum >= {1'b0, rot_len}) ? AW'(step_sum - {1'b0, rot_len})
                                                   : AW'(step_sum);
  assign start_inc  = start + AW'(1);
  assign last_cycle = ({1'b0, start_inc} == cycles);

  // gcd unit launch
  assign gcd_start = accept && (in_action == ivr_pkg::ACT_ROTATE) && (in_dist <= len_eff)
                     && (in_dist != '0) && (in_dist != len_eff);

  ivr_gcd u_gcd (
    .clk    (clk),
    .rst    (rst),
    .start  (gcd_start),
    .a_in   (in_dist),
    .b_in   (len_eff),
    .done   (gcd_done),
    .result (gcd_result)
  );

  // memory port control and completion
  always_comb begin
    mem_we      = 1'b0;
    mem_waddr   = cur;
    mem_wdata   = mem_rdata;
    mem_raddr   = step_nxt;
    done_valid  = 1'b0;
    done_data   = '0;
    done_status = ivr_pkg::ST_OK;
    case (state)
      S_IDLE: begin
        mem_raddr = in_index;
        mem_waddr = in_index;
        mem_wdata = in_value;
        if (accept) begin
          case (in_action)
            ivr_pkg::ACT_WRITE: begin
              done_valid = 1'b1;
              if ({1'b0, in_index} >= len_eff) begin
                done_status = ivr_pkg::ST_BAD_IDX;
              end else begin
                mem_we = 1'b1;
              end
            end
            ivr_pkg::ACT_READ: begin
              if ({1'b0, in_index} >= len_eff) begin
                done_valid  = 1'b1;
                done_status = ivr_pkg::ST_BAD_IDX;
              end
            end
            ivr_pkg::ACT_ROTATE: begin
              if (in_dist > len_eff) begin
                done_valid  = 1'b1;
                done_status = ivr_pkg::ST_BAD_DIST;
              end else if ((in_dist == '0) || (in_dist == len_eff)) begin
                done_valid = 1'b1;
              end
            end
            default: begin
              done_valid = 1'b1;
            end
          endcase
        end
      end
      S_READ: begin
        done_valid = 1'b1;
        done_data  = mem_rdata;
      end
      S_GCD: begin
        mem_raddr = '0;
      end
      S_HELD: begin
        mem_raddr = step_nxt;
      end
      S_MOVE: begin
        mem_we    = 1'b1;
        mem_waddr = cur;
        mem_wdata = mem_rdata;
        mem_raddr = step_nxt;
      end
      S_CLOSE: begin
        mem_we     = 1'b1;
        mem_waddr  = cur;
        mem_wdata  = held;
        mem_raddr  = start_inc;
        done_valid = last_cycle;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  ivr_ram #(
    .ADDR_W (AW),
    .DATA_W (DW)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept && (in_action == ivr_pkg::ACT_READ) && ({1'b0, in_index} < len_eff)) begin
            state <= S_READ;
          end else if (gcd_start) begin
            state <= S_GCD;
          end
        end
        S_READ:  state <= S_IDLE;
        S_GCD: begin
          if (gcd_done) begin
            state <= S_HELD;
          end
        end
        S_HELD:  state <= S_MOVE;
        S_MOVE: begin
          if (step_nxt == start) begin
            state <= S_CLOSE;
          end
        end
        S_CLOSE: state <= last_cycle ? S_IDLE : S_HELD;
        default: state <= S_IDLE;
      endcase
    end
  end

  // rotation datapath registers
  always_ff @(posedge clk) begin
    if (gcd_start) begin
      rot_dist <= in_dist;
      rot_len  <= len_eff;
    end
    case (state)
      S_GCD: begin
        cycles <= gcd_result;
        start  <= '0;
      end
      S_HELD: begin
        held <= mem_rdata;
        cur  <= start;
        ptr  <= step_nxt;
      end
      S_MOVE: begin
        cur <= ptr;
        ptr <= step_nxt;
      end
      S_CLOSE: begin
        start <= start_inc;
      end
      default: begin
        held <= held;
      end
    endcase
  end

  // output register with one pending slot
  assign out_free = !out_valid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      pending   <= 1'b0;
    end else if (out_free) begin
      if (pending) begin
        out_valid <= 1'b1;
        pending   <= 1'b0;
      end else begin
        out_valid <= done_valid;
      end
    end else if (done_valid) begin
      pending <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (pending) begin
        out_data   <= pend_data;
        out_status <= pend_status;
      end else if (done_valid) begin
        out_data   <= done_data;
        out_status <= done_status;
      end
    end else if (done_valid) begin
      pend_data   <= done_data;
      pend_status <= done_status;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;
  assign m_axis_tuser  = out_status;

  // checks
  a_pending_behind_out: assert property (@(posedge clk) disable iff (rst)
    pending |-> out_valid)
    else $error("pending result without a waiting output");

  a_no_done_while_pending: assert property (@(posedge clk) disable iff (rst)
    !(done_valid && pending))
    else $error("completion while a result is still pending");

  a_write_states: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> ((state == S_IDLE) || (state == S_MOVE) || (state == S_CLOSE)))
    else $error("store written outside a write or move step");

  a_move_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_MOVE) |-> (({1'b0, ptr} < rot_len) && ({1'b0, cur} < rot_len)))
    else $error("rotation address beyond length");

endmodule

>>> rtl/ivr_ram.sv
// generic single-write, single-read synchronous ram with registered read data
module ivr_ram #(
  parameter int ADDR_W = 10,
  parameter int DATA_W = 32
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/ivr_gcd.sv
// iterative subtractive gcd, one subtract or swap per cycle
module ivr_gcd (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [ivr_pkg::LEN_W-1:0] a_in,
  input  logic [ivr_pkg::LEN_W-1:0] b_in,
  output logic                     done,
  output logic [ivr_pkg::LEN_W-1:0] result
);

  logic                      busy;
  logic [ivr_pkg::LEN_W-1:0] a;
  logic [ivr_pkg::LEN_W-1:0] b;

  // operand registers and step
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (busy && (a == '0)) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a <= a_in;
      b <= b_in;
    end else if (busy && (a != '0)) begin
      if (b >= a) begin
        b <= b - a;
      end else begin
        a <= b;
        b <= a;
      end
    end
  end

  assign done   = busy && (a == '0);
  assign result = b;

endmodule
